[rtl/core/adl_pkg.sv]
// Shared constants for the audio delay line: field widths, command codes,
// configuration register indexes and reset values. No dependencies.
package adl_pkg;

  // Fixed widths of the channel fields
  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 24;
  localparam int RATE_W   = 16;
  localparam int DLY_W    = 16;
  localparam int CFG_W    = 17;
  localparam int IDX_W    = 2;

  // Reset value of the buffer length register, in samples
  localparam int BUF_LEN_RESET = 48000;
  // Reset value of the rate register, 48.0 samples per ms in Q8.8
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd12288;

  // Command codes carried in the input word
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEFAULT_DELAY = 2'd0;
  localparam logic [IDX_W-1:0] REG_BUFFER_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_RATE_PER_MS   = 2'd2;

endpackage

[rtl/core/audio_delay_line.sv]
// Audio delay line: circular buffer of samples held in one synchronous RAM.
// A sample word passes the multiply, clamp, RAM access and output register
// states; a new word is taken only once its result is loaded and idle returns.
// A clear word, reset, and every buffer_length write start a pass that zeroes
// the RAM one entry per cycle, all STORE_DEPTH entries, with no input words taken.
// Depends on adl_pkg, adl_delay and adl_ram.
module audio_delay_line #(
  parameter int STORE_DEPTH = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic signed [adl_pkg::SAMPLE_W-1:0]   in_sample_in,
  input  logic signed [adl_pkg::TIME_W-1:0]     in_override_time,
  // result words
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [adl_pkg::SAMPLE_W-1:0]   out_sample_out,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [adl_pkg::IDX_W-1:0]      cfg_index,
  input  logic        [adl_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int LEN_RST = (adl_pkg::BUF_LEN_RESET > STORE_DEPTH) ?
                           STORE_DEPTH : adl_pkg::BUF_LEN_RESET;
  localparam logic [AW-1:0] LEN_RST_M1 = AW'(LEN_RST - 1);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_DEPTH - 1);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_PROD   = 6'b000100,
    ST_CLAMP  = 6'b001000,
    ST_ACCESS = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t                              state_r, state_nxt;
  logic [AW-1:0]                       clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]                       wp_r, wp_nxt;
  logic [AW-1:0]                       len_m1_r, len_m1_nxt;
  logic [adl_pkg::DLY_W-1:0]           dflt_delay_r, dflt_delay_nxt;
  logic [adl_pkg::RATE_W-1:0]          rate_r, rate_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic signed [adl_pkg::SAMPLE_W-1:0] out_sample_r;
  logic signed [adl_pkg::TIME_W-1:0]   ovr_r;
  logic signed [SAMPLE_BITS-1:0]       word_r;
  logic                                fwd_r;

  logic                                in_fire;
  logic                                cfg_fire;
  logic                                out_load;
  logic [AW-1:0]                       delay;
  logic [AW-1:0]                       wp_eff;
  logic [AW:0]                         rd_wrap;
  logic [AW-1:0]                       rd_addr;
  logic [AW-1:0]                       cfg_len_m1;
  logic                                ram_wr_en;
  logic [AW-1:0]                       ram_wr_addr;
  logic [SAMPLE_BITS-1:0]              ram_wr_data;
  logic signed [SAMPLE_BITS-1:0]       rd_word;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign out_load  = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Delay from override or default, registered through the product and clamp stages behind ovr_r
  adl_delay #(
    .ADDR_W (AW)
  ) u_delay (
    .clk        (clk),
    .ovr_time   (ovr_r),
    .dflt_delay (dflt_delay_r),
    .rate       (rate_r),
    .len_m1     (len_m1_r),
    .delay_r    (delay)
  );

  // Active length minus one from a buffer_length write, saturated to 1..depth
  always_comb begin
    if (cfg_data == '0) begin
      cfg_len_m1 = '0;
    end else if (32'(cfg_data) > 32'(STORE_DEPTH)) begin
      cfg_len_m1 = LAST_ADDR;
    end else begin
      cfg_len_m1 = AW'(cfg_data - adl_pkg::CFG_W'(1));
    end
  end

  // Read address: wp minus delay, wrapping within the active length
  assign wp_eff  = (wp_r > len_m1_r) ? '0 : wp_r;
  assign rd_wrap = {1'b0, wp_eff} + {1'b0, len_m1_r} + (AW + 1)'(1) - {1'b0, delay};
  assign rd_addr = (wp_eff >= delay) ? (wp_eff - delay) : rd_wrap[AW-1:0];

  // RAM write port: clearing pass or sample write
  always_comb begin
    ram_wr_en   = (state_r == ST_CLEAR) || (state_r == ST_ACCESS);
    ram_wr_addr = (state_r == ST_CLEAR) ? clr_cnt_r : wp_eff;
    ram_wr_data = (state_r == ST_CLEAR) ? '0 : word_r;
  end

  adl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (state_r == ST_ACCESS),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  // Sequencer, write position and configuration registers
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    wp_nxt         = wp_r;
    len_m1_nxt     = len_m1_r;
    dflt_delay_nxt = dflt_delay_r;
    rate_nxt       = rate_r;
    out_valid_nxt  = out_valid_r;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_command == adl_pkg::CMD_CLEAR) begin
            state_nxt   = ST_CLEAR;
            clr_cnt_nxt = '0;
          end else begin
            state_nxt = ST_PROD;
          end
        end
      end
      ST_PROD:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_ACCESS;
      ST_ACCESS: begin
        wp_nxt    = (wp_eff == len_m1_r) ? '0 : wp_eff + AW'(1);
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    // register writes; a length write restarts the clearing pass
    if (cfg_fire) begin
      case (cfg_index)
        adl_pkg::REG_DEFAULT_DELAY: dflt_delay_nxt = cfg_data[adl_pkg::DLY_W-1:0];
        adl_pkg::REG_BUFFER_LENGTH: begin
          len_m1_nxt  = cfg_len_m1;
          wp_nxt      = '0;
          clr_cnt_nxt = '0;
          state_nxt   = ST_CLEAR;
        end
        adl_pkg::REG_RATE_PER_MS: rate_nxt = cfg_data[adl_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      wp_r         <= '0;
      len_m1_r     <= LEN_RST_M1;
      dflt_delay_r <= '0;
      rate_r       <= adl_pkg::RATE_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      wp_r         <= wp_nxt;
      len_m1_r     <= len_m1_nxt;
      dflt_delay_r <= dflt_delay_nxt;
      rate_r       <= rate_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: hold the accepted word, flag a zero delay for forwarding
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ovr_r  <= in_override_time;
      word_r <= SAMPLE_BITS'(in_sample_in);
    end
    if (state_r == ST_ACCESS) begin
      fwd_r <= (delay == '0);
    end
    if (out_load) begin
      out_sample_r <= fwd_r ? adl_pkg::SAMPLE_W'(word_r) : adl_pkg::SAMPLE_W'(rd_word);
    end
  end

endmodule

[rtl/core/adl_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents.
module adl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/adl_delay.sv]
// Two-stage delay calculation: override time times rate, or the default delay
// for no override; clamp to the active length. Uses adl_pkg for field widths.
module adl_delay #(
  parameter int ADDR_W = 16
) (
  input  logic                                clk,
  input  logic signed [adl_pkg::TIME_W-1:0]   ovr_time,
  input  logic        [adl_pkg::DLY_W-1:0]    dflt_delay,
  input  logic        [adl_pkg::RATE_W-1:0]   rate,
  input  logic        [ADDR_W-1:0]            len_m1,
  output logic        [ADDR_W-1:0]            delay_r
);

  localparam int MAG_W  = adl_pkg::TIME_W - 1;
  localparam int PROD_W = MAG_W + adl_pkg::RATE_W;

  logic [PROD_W-1:0] prod_r;
  logic              zero_r;
  logic              neg_r;
  logic [MAG_W-1:0]  samples;
  logic [ADDR_W-1:0] delay_nxt;

  // Stage one: multiply the magnitude of a positive override by the rate
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(ovr_time[MAG_W-1:0]) * PROD_W'(rate);
    zero_r <= (ovr_time == '0);
    neg_r  <= ovr_time[adl_pkg::TIME_W-1];
  end

  // Drop the eight fraction bits of the time and the eight of the rate
  assign samples = prod_r[PROD_W-1:adl_pkg::RATE_W];

  // Stage two: select the source and clamp to length minus one
  always_comb begin
    if (zero_r) begin
      delay_nxt = (32'(dflt_delay) > 32'(len_m1)) ? len_m1 : ADDR_W'(dflt_delay);
    end else if (neg_r) begin
      delay_nxt = '0;
    end else begin
      delay_nxt = (32'(samples) > 32'(len_m1)) ? len_m1 : ADDR_W'(samples);
    end
  end

  always_ff @(posedge clk) begin
    delay_r <= delay_nxt;
  end

endmodule
